// ----- design/i2c_master_bit_sequencer_core_macros.svh -----
// Assertion helpers shared by the sequencer modules.
// Each helper expects clk and rst_n in scope.
`ifndef I2C_MASTER_BIT_SEQUENCER_CORE_MACROS_SVH
`define I2C_MASTER_BIT_SEQUENCER_CORE_MACROS_SVH

// Same-cycle implication
`define I2CMS_ASSERT_HOLDS(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2cms: same-cycle check failed");

// Next-cycle implication
`define I2CMS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2cms: next-cycle check failed");

`endif

// ----- design/i2cms_pkg.sv -----
`timescale 1ns / 1ps

package i2cms_pkg;

    localparam int QDEPTH = 2;

    typedef enum logic [2:0] {
        CMD_START     = 3'd0,
        CMD_STOP      = 3'd1,
        CMD_SEND_BYTE = 3'd2,
        CMD_RECV_BYTE = 3'd3,
        CMD_SEND_ACK  = 3'd4,
        CMD_RECV_ACK  = 3'd5
    } cmd_e;

    typedef enum logic [1:0] {
        KIND_SCL    = 2'd0,
        KIND_SDA    = 2'd1,
        KIND_SAMPLE = 2'd2
    } kind_e;

    // Classified command handed from front to back
    typedef struct packed {
        cmd_e       op;
        logic [7:0] bits;   // bits to drive or to sample, MSB first
        logic [7:0] rd;     // value reported on the last step
    } desc_t;

    // One pin step
    typedef struct packed {
        kind_e kind;
        logic  level;
        logic  last;
    } step_t;

    // Map the back end's position within a command onto a pin step
    function automatic step_t step_decode(
        input cmd_e       op,
        input logic       pre,
        input logic [1:0] phase,
        input logic [2:0] bit_idx,
        input logic       msb
    );
        step_t s;
        logic  byte_end;
        s.kind  = KIND_SCL;
        s.level = 1'b0;
        s.last  = 1'b0;
        byte_end = (bit_idx == 3'd7);
        unique case (op)
            CMD_START:
            begin
                case (phase)
                    2'd0:    begin s.kind = KIND_SDA; s.level = 1'b1; end
                    2'd1:    begin s.kind = KIND_SCL; s.level = 1'b1; end
                    2'd2:    begin s.kind = KIND_SDA; s.level = 1'b0; end
                    default: begin s.kind = KIND_SCL; s.level = 1'b0; s.last = 1'b1; end
                endcase
            end
            CMD_STOP:
            begin
                case (phase)
                    2'd0:    begin s.kind = KIND_SDA; s.level = 1'b0; end
                    2'd1:    begin s.kind = KIND_SCL; s.level = 1'b1; end
                    default: begin s.kind = KIND_SDA; s.level = 1'b1; s.last = 1'b1; end
                endcase
            end
            CMD_SEND_BYTE:
            begin
                case (phase)
                    2'd0:    begin s.kind = KIND_SDA; s.level = msb; end
                    2'd1:    begin s.kind = KIND_SCL; s.level = 1'b1; end
                    default: begin s.kind = KIND_SCL; s.level = 1'b0; s.last = byte_end; end
                endcase
            end
            CMD_RECV_BYTE:
            begin
                if (pre)
                begin
                    s.kind  = (phase == 2'd0) ? KIND_SDA : KIND_SCL;
                    s.level = 1'b1;
                end
                else
                begin
                    case (phase)
                        2'd0:    begin s.kind = KIND_SCL; s.level = 1'b1; end
                        2'd1:    begin s.kind = KIND_SAMPLE; s.level = msb; end
                        default: begin s.kind = KIND_SCL; s.level = 1'b0; s.last = byte_end; end
                    endcase
                end
            end
            CMD_SEND_ACK:
            begin
                case (phase)
                    2'd0:    begin s.kind = KIND_SDA; s.level = msb; end
                    2'd1:    begin s.kind = KIND_SCL; s.level = 1'b1; end
                    default: begin s.kind = KIND_SCL; s.level = 1'b0; s.last = 1'b1; end
                endcase
            end
            CMD_RECV_ACK:
            begin
                case (phase)
                    2'd0:    begin s.kind = KIND_SDA; s.level = 1'b1; end
                    2'd1:    begin s.kind = KIND_SCL; s.level = 1'b1; end
                    2'd2:    begin s.kind = KIND_SAMPLE; s.level = msb; end
                    default: begin s.kind = KIND_SCL; s.level = 1'b0; s.last = 1'b1; end
                endcase
            end
            default:
            begin
                s.last = 1'b1;
            end
        endcase
        return s;
    endfunction

endpackage

// ----- design/i2cms_cmd_if.sv -----
`timescale 1ns / 1ps

interface i2cms_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [7:0] data_byte;
    logic       ack_bit;
    logic [7:0] sda_levels;

    modport source (output valid, command, data_byte, ack_bit, sda_levels, input ready);
    modport sink   (input valid, command, data_byte, ack_bit, sda_levels, output ready);
endinterface

// ----- design/i2cms_step_if.sv -----
`timescale 1ns / 1ps

interface i2cms_step_if;
    logic       valid;
    logic       ready;
    logic [1:0] step_kind;
    logic       level;
    logic [7:0] read_value;
    logic       last;

    modport source (output valid, step_kind, level, read_value, last, input ready);
    modport sink   (input valid, step_kind, level, read_value, last, output ready);
endinterface

// ----- design/i2c_master_bit_sequencer_core.sv -----
`timescale 1ns / 1ps
// The first pin step of a command, with the queue empty and the step engine idle, passes through
// the queue slot, the step engine's load and the output register before it is valid.
// Throughput: one pin step per cycle within a command while the step sink takes each word;
// the step engine loads the next command only after the last step of the current one is emitted.
// Reset (rst_n, asynchronous, active low) empties the two-word queue and the output register.

module i2c_master_bit_sequencer_core (
    input  logic         clk,
    input  logic         rst_n,
    i2cms_cmd_if.sink    cmd,
    i2cms_step_if.source step
);

    logic             fq_valid, fq_ready;
    i2cms_pkg::desc_t fq_desc;
    logic             qb_valid, qb_ready;
    i2cms_pkg::desc_t qb_desc;

    i2cms_front u_front (
        .cmd     (cmd),
        .q_ready (fq_ready),
        .q_valid (fq_valid),
        .q_desc  (fq_desc)
    );

    i2cms_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_desc  (fq_desc),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_desc  (qb_desc)
    );

    i2cms_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (qb_valid),
        .q_ready (qb_ready),
        .q_desc  (qb_desc),
        .step    (step)
    );

endmodule

// ----- design/i2cms_front.sv -----
`timescale 1ns / 1ps

module i2cms_front (
    i2cms_cmd_if.sink       cmd,
    input  logic            q_ready,
    output logic            q_valid,
    output i2cms_pkg::desc_t q_desc
);

    i2cms_pkg::cmd_e op;
    logic            known;

    assign op = i2cms_pkg::cmd_e'(cmd.command);

    // Classify the command and pick the bits the back end shifts through
    always_comb
    begin
        known       = 1'b1;
        q_desc.op   = op;
        q_desc.bits = 8'd0;
        q_desc.rd   = 8'd0;
        unique case (op)
            i2cms_pkg::CMD_START,
            i2cms_pkg::CMD_STOP:
            begin
            end
            i2cms_pkg::CMD_SEND_BYTE:
            begin
                q_desc.bits = cmd.data_byte;
            end
            i2cms_pkg::CMD_RECV_BYTE:
            begin
                q_desc.bits = cmd.sda_levels;
                q_desc.rd   = cmd.sda_levels;
            end
            i2cms_pkg::CMD_SEND_ACK:
            begin
                q_desc.bits = {cmd.ack_bit, 7'd0};
            end
            i2cms_pkg::CMD_RECV_ACK:
            begin
                q_desc.bits = cmd.sda_levels;
                q_desc.rd   = {7'd0, cmd.sda_levels[7]};
            end
            default:
            begin
                known = 1'b0;
            end
        endcase
    end

    // Drop unknown commands at the door; queue the rest
    assign cmd.ready = q_ready;
    assign q_valid   = cmd.valid && known;

endmodule

// ----- design/i2cms_queue.sv -----
`timescale 1ns / 1ps

`include "i2c_master_bit_sequencer_core_macros.svh"

module i2cms_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  i2cms_pkg::desc_t wr_desc,
    output logic             rd_valid,
    input  logic             rd_ready,
    output i2cms_pkg::desc_t rd_desc
);

    localparam int PTR_W = (i2cms_pkg::QDEPTH > 1) ? $clog2(i2cms_pkg::QDEPTH) : 1;
    localparam int CNT_W = $clog2(i2cms_pkg::QDEPTH + 1);

    i2cms_pkg::desc_t   slot_reg [i2cms_pkg::QDEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push, pop;

    assign wr_ready = (count_reg != CNT_W'(i2cms_pkg::QDEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_desc  = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Advance pointers with wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(i2cms_pkg::QDEPTH - 1)) ? '0
                                                                         : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(i2cms_pkg::QDEPTH - 1)) ? '0
                                                                         : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming word
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_desc;
        end
    end

    `I2CMS_ASSERT_NEXT(a_q_fill, push && !pop, count_reg == $past(count_reg) + 1'b1)
    `I2CMS_ASSERT_NEXT(a_q_drain, pop && !push, count_reg == $past(count_reg) - 1'b1)
    `I2CMS_ASSERT_NEXT(a_q_head, push && (count_reg == '0), rd_desc == $past(wr_desc))

endmodule

// ----- design/i2cms_back.sv -----
`timescale 1ns / 1ps

`include "i2c_master_bit_sequencer_core_macros.svh"

module i2cms_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    output logic             q_ready,
    input  i2cms_pkg::desc_t q_desc,
    i2cms_step_if.source     step
);

    logic            busy_reg, busy_next;
    logic            pre_reg, pre_next;
    logic [1:0]      phase_reg, phase_next;
    logic [2:0]      bit_reg, bit_next;
    logic [7:0]      bits_reg, bits_next;
    i2cms_pkg::cmd_e op_reg;
    logic [7:0]      rd_reg;
    logic            out_valid_reg, out_valid_next;
    logic [1:0]      out_kind_reg;
    logic            out_level_reg;
    logic [7:0]      out_read_reg;
    logic            out_last_reg;
    i2cms_pkg::step_t cur;
    logic            load, emit, byte_op;

    assign q_ready = !busy_reg;
    assign load    = q_valid && q_ready;
    assign emit    = busy_reg && (!out_valid_reg || step.ready);
    assign byte_op = (op_reg == i2cms_pkg::CMD_SEND_BYTE) ||
                     (op_reg == i2cms_pkg::CMD_RECV_BYTE);

    assign cur = i2cms_pkg::step_decode(op_reg, pre_reg, phase_reg, bit_reg, bits_reg[7]);

    // Walk the step position: receive-byte prologue, three steps per bit for bytes, else phase by phase
    always_comb
    begin
        busy_next  = busy_reg;
        pre_next   = pre_reg;
        phase_next = phase_reg;
        bit_next   = bit_reg;
        bits_next  = bits_reg;
        if (load)
        begin
            busy_next  = 1'b1;
            pre_next   = (q_desc.op == i2cms_pkg::CMD_RECV_BYTE);
            phase_next = 2'd0;
            bit_next   = 3'd0;
            bits_next  = q_desc.bits;
        end
        else if (emit)
        begin
            if (cur.last)
            begin
                busy_next = 1'b0;
            end
            else if (pre_reg && (phase_reg == 2'd1))
            begin
                pre_next   = 1'b0;
                phase_next = 2'd0;
            end
            else if (byte_op && !pre_reg && (phase_reg == 2'd2))
            begin
                phase_next = 2'd0;
                bit_next   = bit_reg + 1'b1;
                bits_next  = {bits_reg[6:0], 1'b0};
            end
            else
            begin
                phase_next = phase_reg + 1'b1;
            end
        end
    end

    // Hold the output word until it is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (step.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Position and payload registers
    always_ff @(posedge clk)
    begin
        pre_reg   <= pre_next;
        phase_reg <= phase_next;
        bit_reg   <= bit_next;
        bits_reg  <= bits_next;
        if (load)
        begin
            op_reg <= q_desc.op;
            rd_reg <= q_desc.rd;
        end
        if (emit)
        begin
            out_kind_reg  <= cur.kind;
            out_level_reg <= cur.level;
            out_read_reg  <= cur.last ? rd_reg : 8'd0;
            out_last_reg  <= cur.last;
        end
    end

    assign step.valid      = out_valid_reg;
    assign step.step_kind  = out_kind_reg;
    assign step.level      = out_level_reg;
    assign step.read_value = out_read_reg;
    assign step.last       = out_last_reg;

    `I2CMS_ASSERT_NEXT(a_bk_done, emit && cur.last, !busy_reg)
    `I2CMS_ASSERT_NEXT(a_bk_load, load, busy_reg && (phase_reg == 2'd0) && (bit_reg == 3'd0))
    `I2CMS_ASSERT_HOLDS(a_bk_rdzero, out_valid_reg && !out_last_reg, out_read_reg == 8'd0)

endmodule

// ----- tb/i2c_master_bit_sequencer_core_checker.sv -----
`timescale 1ns / 1ps

module i2c_master_bit_sequencer_core_checker (
    input  logic  clk,
    input  logic  rst_n,
    i2cms_cmd_if  cmd,
    i2cms_step_if step,
    output int    fail_count,
    output int    pending
);

    typedef struct packed {
        i2cms_pkg::kind_e kind;
        logic             level;
        logic [7:0]       read_value;
        logic             last;
    } pin_step_t;

    pin_step_t expected_steps[$];

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    // Queue one pin step with no read value
    function automatic void add_step(input i2cms_pkg::kind_e kind, input logic lvl);
        pin_step_t s;
        s.kind       = kind;
        s.level      = lvl;
        s.read_value = 8'd0;
        s.last       = 1'b0;
        expected_steps.push_back(s);
    endfunction

    // Expand one command word into the pin steps it should produce
    function automatic void expand_command(
        input logic [2:0] code,
        input logic [7:0] data,
        input logic       ack,
        input logic [7:0] sda
    );
        int         first_size;
        logic [7:0] value;
        pin_step_t  tail;
        first_size = expected_steps.size();
        value      = 8'd0;
        case (code)
            i2cms_pkg::CMD_START:
            begin
                add_step(i2cms_pkg::KIND_SDA, 1'b1);
                add_step(i2cms_pkg::KIND_SCL, 1'b1);
                add_step(i2cms_pkg::KIND_SDA, 1'b0);
                add_step(i2cms_pkg::KIND_SCL, 1'b0);
            end
            i2cms_pkg::CMD_STOP:
            begin
                add_step(i2cms_pkg::KIND_SDA, 1'b0);
                add_step(i2cms_pkg::KIND_SCL, 1'b1);
                add_step(i2cms_pkg::KIND_SDA, 1'b1);
            end
            i2cms_pkg::CMD_SEND_BYTE:
            begin
                for (int i = 7; i >= 0; i--)
                begin
                    add_step(i2cms_pkg::KIND_SDA, data[i]);
                    add_step(i2cms_pkg::KIND_SCL, 1'b1);
                    add_step(i2cms_pkg::KIND_SCL, 1'b0);
                end
            end
            i2cms_pkg::CMD_RECV_BYTE:
            begin
                // release SDA and raise SCL before the eight bit slots
                add_step(i2cms_pkg::KIND_SDA, 1'b1);
                add_step(i2cms_pkg::KIND_SCL, 1'b1);
                for (int i = 7; i >= 0; i--)
                begin
                    add_step(i2cms_pkg::KIND_SCL, 1'b1);
                    add_step(i2cms_pkg::KIND_SAMPLE, sda[i]);
                    add_step(i2cms_pkg::KIND_SCL, 1'b0);
                end
                value = sda;
            end
            i2cms_pkg::CMD_SEND_ACK:
            begin
                add_step(i2cms_pkg::KIND_SDA, ack);
                add_step(i2cms_pkg::KIND_SCL, 1'b1);
                add_step(i2cms_pkg::KIND_SCL, 1'b0);
            end
            i2cms_pkg::CMD_RECV_ACK:
            begin
                add_step(i2cms_pkg::KIND_SDA, 1'b1);
                add_step(i2cms_pkg::KIND_SCL, 1'b1);
                add_step(i2cms_pkg::KIND_SAMPLE, sda[7]);
                add_step(i2cms_pkg::KIND_SCL, 1'b0);
                value = {7'd0, sda[7]};
            end
            default:
            begin
                // unknown codes produce nothing
            end
        endcase
        // Mark the final step and attach the read value
        if (expected_steps.size() > first_size)
        begin
            tail            = expected_steps.pop_back();
            tail.read_value = value;
            tail.last       = 1'b1;
            expected_steps.push_back(tail);
        end
    endfunction

    // Compare each accepted step word, then expand each accepted command word
    always @(posedge clk)
    begin
        pin_step_t want;
        if (rst_n)
        begin
            if (step.valid && step.ready)
            begin
                if (expected_steps.size() == 0)
                begin
                    $error("unexpected pin step: step_kind %0d level %0d read_value %0d last %0d",
                           step.step_kind, step.level, step.read_value, step.last);
                    fail_count++;
                end
                else
                begin
                    want = expected_steps.pop_front();
                    if (step.step_kind !== want.kind)
                    begin
                        $error("step_kind: expected %0d, got %0d", want.kind, step.step_kind);
                        fail_count++;
                    end
                    if (step.level !== want.level)
                    begin
                        $error("level: expected %0d, got %0d", want.level, step.level);
                        fail_count++;
                    end
                    if (step.read_value !== want.read_value)
                    begin
                        $error("read_value: expected %0d, got %0d",
                               want.read_value, step.read_value);
                        fail_count++;
                    end
                    if (step.last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, step.last);
                        fail_count++;
                    end
                end
            end
            if (cmd.valid && cmd.ready)
                expand_command(cmd.command, cmd.data_byte, cmd.ack_bit, cmd.sda_levels);
            pending = expected_steps.size();
        end
    end

endmodule

// ----- tb/i2c_master_bit_sequencer_core_test.sv -----
`timescale 1ns / 1ps

module i2c_master_bit_sequencer_core_test;

    localparam int         CYCLE_LIMIT   = 500000;
    localparam int         DRAIN_CYCLES  = 40;
    localparam int         RANDOM_WORDS  = 80;
    localparam logic [2:0] CMD_UNKNOWN_LO = 3'd6;
    localparam logic [2:0] CMD_UNKNOWN_HI = 3'd7;

    logic clk;
    logic rst_n;
    bit   steady;
    int   fail_count;
    int   pending;
    int   cycle_count = 0;

    i2cms_cmd_if  cmd ();
    i2cms_step_if step ();

    i2c_master_bit_sequencer_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .step  (step)
    );

    i2c_master_bit_sequencer_core_checker pin_step_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .step       (step),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Offer one command word after a random gap and hold it until taken
    task automatic send_command(
        input logic [2:0] code,
        input logic [7:0] data,
        input logic       ack,
        input logic [7:0] sda
    );
        int gap;
        gap = steady ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            cmd.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd.valid      <= 1'b1;
        cmd.command    <= code;
        cmd.data_byte  <= data;
        cmd.ack_bit    <= ack;
        cmd.sda_levels <= sda;
        do
            @(posedge clk);
        while (!cmd.ready);
        @(negedge clk);
    endtask

    // Draw a command word, mostly known codes with a few unknown ones
    task automatic send_random_command();
        logic [2:0] code;
        if ($urandom_range(0, 9) == 0)
            code = 3'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI));
        else
            code = 3'($urandom_range(i2cms_pkg::CMD_START, i2cms_pkg::CMD_RECV_ACK));
        send_command(code, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                     8'($urandom_range(0, 255)));
    endtask

    // Step sink: stall a random number of cycles before each word
    initial
    begin
        int stall;
        step.ready = 1'b0;
        @(negedge clk);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                step.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            step.ready <= 1'b1;
            do
                @(posedge clk);
            while (!step.valid);
            @(negedge clk);
        end
    end

    // Command source and verdict
    initial
    begin
        rst_n          = 1'b0;
        steady         = 1'b0;
        cmd.valid      = 1'b0;
        cmd.command    = i2cms_pkg::CMD_START;
        cmd.data_byte  = 8'd0;
        cmd.ack_bit    = 1'b0;
        cmd.sda_levels = 8'd0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: every command, field extremes and unknown codes
        send_command(i2cms_pkg::CMD_START, 8'h00, 1'b0, 8'h00);
        send_command(i2cms_pkg::CMD_SEND_BYTE, 8'h00, 1'b1, 8'hFF);
        send_command(i2cms_pkg::CMD_SEND_BYTE, 8'hFF, 1'b0, 8'h00);
        send_command(i2cms_pkg::CMD_SEND_BYTE, 8'hA5, 1'b1, 8'h5A);
        send_command(i2cms_pkg::CMD_SEND_BYTE, 8'h5A, 1'b0, 8'hA5);
        send_command(i2cms_pkg::CMD_SEND_ACK, 8'hFF, 1'b0, 8'hFF);
        send_command(i2cms_pkg::CMD_RECV_BYTE, 8'hFF, 1'b1, 8'h00);
        send_command(i2cms_pkg::CMD_RECV_BYTE, 8'h00, 1'b0, 8'hFF);
        send_command(i2cms_pkg::CMD_RECV_BYTE, 8'h3C, 1'b1, 8'h96);
        send_command(i2cms_pkg::CMD_RECV_BYTE, 8'hC3, 1'b0, 8'h69);
        send_command(i2cms_pkg::CMD_SEND_ACK, 8'h00, 1'b1, 8'h00);
        send_command(i2cms_pkg::CMD_RECV_ACK, 8'hFF, 1'b1, 8'h00);
        send_command(i2cms_pkg::CMD_RECV_ACK, 8'h00, 1'b0, 8'h80);
        send_command(i2cms_pkg::CMD_RECV_ACK, 8'h55, 1'b1, 8'h7F);
        send_command(i2cms_pkg::CMD_STOP, 8'hFF, 1'b1, 8'hFF);
        send_command(CMD_UNKNOWN_LO, 8'hFF, 1'b1, 8'hFF);
        send_command(CMD_UNKNOWN_HI, 8'h00, 1'b0, 8'h00);
        send_command(i2cms_pkg::CMD_START, 8'hFF, 1'b1, 8'hFF);
        send_command(i2cms_pkg::CMD_STOP, 8'h00, 1'b0, 8'h00);

        // Random: back-to-back stretch in the last quarter of every forty words
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            steady = (n % 40) >= 30;
            send_random_command();
        end
        steady = 1'b0;
        cmd.valid <= 1'b0;

        // Drain the expected steps, then watch for stray words
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
